// ===== design/bep_pkg.sv =====
package bep_pkg;

    // character width of one input item
    localparam int CHAR_BITS = 8;

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    // operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    // status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_NO_NUMBER   = 3'd1;
    localparam t_status ST_BAD_OP      = 3'd2;
    localparam t_status ST_BAD_CHAR    = 3'd3;
    localparam t_status ST_LEFT_RANGE  = 3'd4;
    localparam t_status ST_RIGHT_RANGE = 3'd5;

    // parse phase, one-hot
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_OPER   = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

endpackage

// ===== design/bep_char_if.sv =====
interface bep_char_if
    import bep_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

// ===== design/bep_result_if.sv =====
interface bep_result_if
    import bep_pkg::*;
#(
    parameter int VALUE_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    t_op                          operation;
    logic signed [VALUE_BITS-1:0] left_value;
    logic signed [VALUE_BITS-1:0] right_value;
    t_status                      status;

    modport source (
        output valid, output operation, output left_value, output right_value,
        output status, input ready
    );
    modport sink (
        input valid, input operation, input left_value, input right_value,
        input status, output ready
    );
endinterface

// ===== design/binary_expression_parser.sv =====
// Line parser for "number op number", one character per item.
// Items pass the input register; a terminator then waits for a free result slot.
// Throughput: one item per cycle save that wait; the parse state update (compare
// plus a shift-add multiply-by-ten accumulate) is a single registered step.
// Reset (i_rst_n low, synchronous) empties both stages and returns to line start.
module binary_expression_parser
    import bep_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bep_char_if.sink            i_char,
    bep_result_if.source        o_res
);

    localparam int MAG_W = VALUE_BITS + 1;
    localparam int PROD_W = MAG_W + 4;
    localparam logic [MAG_W-1:0] HALF_RANGE = {2'b01, {(VALUE_BITS-1){1'b0}}};
    localparam logic [MAG_W-1:0] MAG_CAP = HALF_RANGE + MAG_W'(1);

    // mag * 10 + digit, saturating at the cap
    function automatic logic [MAG_W-1:0] f_acc(input logic [MAG_W-1:0] mag,
                                               input logic [3:0] digit);
        logic [PROD_W-1:0] prod;
        prod = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {{MAG_W{1'b0}}, digit};
        if (prod > {4'b0, MAG_CAP}) begin
            return MAG_CAP;
        end
        return prod[MAG_W-1:0];
    endfunction

    function automatic logic f_in_range(input logic [MAG_W-1:0] mag, input logic neg);
        return neg ? (mag <= HALF_RANGE) : (mag < HALF_RANGE);
    endfunction

    function automatic logic [VALUE_BITS-1:0] f_value(input logic [MAG_W-1:0] mag,
                                                      input logic neg);
        logic [MAG_W-1:0] v;
        v = neg ? (MAG_W'(0) - mag) : mag;
        return v[VALUE_BITS-1:0];
    endfunction

    // input stage
    logic                 r_in_valid;
    logic [CHAR_BITS-1:0] r_char;

    // parse state
    t_phase           r_phase, n_phase;
    logic             r_at_start, n_at_start;
    t_status          r_err, n_err;
    logic [MAG_W-1:0] r_lmag, n_lmag;
    logic             r_lneg, n_lneg;
    logic             r_lhas, n_lhas;
    logic [MAG_W-1:0] r_rmag, n_rmag;
    logic             r_rneg, n_rneg;
    logic             r_rhas, n_rhas;
    t_op              r_op, n_op;

    // result stage
    logic                  r_res_valid;
    t_op                   r_res_op, n_res_op;
    logic [VALUE_BITS-1:0] r_res_left, n_res_left;
    logic [VALUE_BITS-1:0] r_res_right, n_res_right;
    t_status               r_res_status, n_res_status;

    logic w_term, w_digit, w_fire, w_res_free, w_op_hit;
    t_op  w_op_code;

    // character classes
    assign w_term  = (r_char == CH_NL) || (r_char == CH_NUL);
    assign w_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);

    always_comb begin
        w_op_hit  = 1'b1;
        w_op_code = OP_ADD;
        case (r_char)
            CH_PLUS:  w_op_code = OP_ADD;
            CH_MINUS: w_op_code = OP_SUB;
            CH_STAR:  w_op_code = OP_MUL;
            CH_SLASH: w_op_code = OP_DIV;
            default:  w_op_hit  = 1'b0;
        endcase
    end

    // handshake: a terminator item waits for a free result slot
    assign w_res_free  = !r_res_valid || o_res.ready;
    assign w_fire      = r_in_valid && (!w_term || w_res_free);
    assign i_char.ready = !r_in_valid || w_fire;

    // next parse state and result
    always_comb begin
        t_status st;
        n_phase    = r_phase;
        n_at_start = r_at_start;
        n_err      = r_err;
        n_lmag     = r_lmag;
        n_lneg     = r_lneg;
        n_lhas     = r_lhas;
        n_rmag     = r_rmag;
        n_rneg     = r_rneg;
        n_rhas     = r_rhas;
        n_op       = r_op;
        st         = r_err;
        n_res_op     = OP_ADD;
        n_res_left   = '0;
        n_res_right  = '0;
        n_res_status = ST_OK;
        if (w_term) begin
            if (st == ST_OK) begin
                if (r_phase == PH_FIRST) begin
                    st = r_at_start ? ST_NO_NUMBER : ST_BAD_OP;
                end else if (r_phase == PH_OPER) begin
                    st = ST_BAD_OP;
                end else if (!f_in_range(r_lmag, r_lneg)) begin
                    st = ST_LEFT_RANGE;
                end else if (!f_in_range(r_rmag, r_rneg)) begin
                    st = ST_RIGHT_RANGE;
                end
            end
            if (st == ST_OK) begin
                n_res_op    = r_op;
                n_res_left  = f_value(r_lmag, r_lneg);
                n_res_right = f_value(r_rmag, r_rneg);
            end
            n_res_status = st;
            // back to line start
            n_phase    = PH_FIRST;
            n_at_start = 1'b1;
            n_err      = ST_OK;
            n_lmag     = '0;
            n_lneg     = 1'b0;
            n_lhas     = 1'b0;
            n_rmag     = '0;
            n_rneg     = 1'b0;
            n_rhas     = 1'b0;
            n_op       = OP_ADD;
        end else if (r_err == ST_OK) begin
            case (r_phase)
                PH_FIRST: begin
                    n_at_start = 1'b0;
                    if (w_digit) begin
                        n_lmag = f_acc(r_lmag, r_char[3:0]);
                        n_lhas = 1'b1;
                    end else if (r_char == CH_MINUS && !r_lhas) begin
                        n_lneg = 1'b1;
                        n_lhas = 1'b1;
                    end else if (r_at_start) begin
                        n_err = ST_NO_NUMBER;
                    end else if (w_op_hit) begin
                        n_op    = w_op_code;
                        n_phase = PH_SECOND;
                    end else if (r_char == CH_SPACE) begin
                        n_phase = PH_OPER;
                    end else begin
                        n_phase = PH_OPER;
                        n_err   = ST_BAD_OP;
                    end
                end
                PH_OPER: begin
                    if (w_op_hit) begin
                        n_op    = w_op_code;
                        n_phase = PH_SECOND;
                    end else if (r_char != CH_SPACE) begin
                        n_err = ST_BAD_OP;
                    end
                end
                PH_SECOND: begin
                    if (w_digit) begin
                        n_rmag = f_acc(r_rmag, r_char[3:0]);
                        n_rhas = 1'b1;
                    end else if (r_char == CH_MINUS && !r_rhas) begin
                        n_rneg = 1'b1;
                        n_rhas = 1'b1;
                    end else if (r_char != CH_SPACE) begin
                        n_err = ST_BAD_CHAR;
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_code;
        end
    end

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_at_start <= 1'b1;
            r_err      <= ST_OK;
            r_lmag     <= '0;
            r_lneg     <= 1'b0;
            r_lhas     <= 1'b0;
            r_rmag     <= '0;
            r_rneg     <= 1'b0;
            r_rhas     <= 1'b0;
            r_op       <= OP_ADD;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_at_start <= n_at_start;
            r_err      <= n_err;
            r_lmag     <= n_lmag;
            r_lneg     <= n_lneg;
            r_lhas     <= n_lhas;
            r_rmag     <= n_rmag;
            r_rneg     <= n_rneg;
            r_rhas     <= n_rhas;
            r_op       <= n_op;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_fire && w_term) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
        if (w_fire && w_term) begin
            r_res_op     <= n_res_op;
            r_res_left   <= n_res_left;
            r_res_right  <= n_res_right;
            r_res_status <= n_res_status;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.operation   = r_res_op;
    assign o_res.left_value  = r_res_left;
    assign o_res.right_value = r_res_right;
    assign o_res.status      = r_res_status;

`ifndef SYNTHESIS
    // a line end always lands in the result register
    a_term_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_term) |=> r_res_valid)
        else $error("line end did not produce a result");

    // failed lines carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_status != ST_OK) |->
        (r_res_op == OP_ADD && r_res_left == '0 && r_res_right == '0))
        else $error("error result with nonzero fields");

    // a line end restores line-start state
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_term) |=>
        (r_at_start && r_phase == PH_FIRST && r_err == ST_OK && !r_lhas && !r_rhas))
        else $error("parse state not cleared after line end");

    // magnitudes saturate at the cap
    a_mag_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lmag <= MAG_CAP && r_rmag <= MAG_CAP))
        else $error("magnitude above saturation cap");

    // a pending result is held until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |=> r_res_valid)
        else $error("pending result dropped");
`endif

endmodule
